// File: rtl/trbct_pkg.sv
package trbct_pkg;

	typedef enum logic [1:0] {
		CMD_ACCUMULATE = 2'd0,
		CMD_QUANTIZE   = 2'd1,
		CMD_READ       = 2'd2,
		CMD_CLEAR      = 2'd3
	} command_t;

	localparam logic [7:0] TABLE_LENGTH_RESET = 8'd60;

	typedef struct packed {
		logic [1:0]         command;
		logic [11:0]        position;
		logic signed [23:0] value;
		logic [7:0]         bin;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  bin_index;
		logic        clamped;
		logic [15:0] cumulative_count;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_QUANT,
		ST_ACC_RD,
		ST_ACC_WR,
		ST_SUM,
		ST_SUM_END,
		ST_ROW_CLR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic quant;
		logic init_step;
		logic acc_rd;
		logic acc_wr;
		logic sum_rd;
		logic row_clr;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		command_t op;
		logic     pos_ok;
		logic     n_zero;
		logic     sum_last;
		logic     row_last;
		logic     init_last;
	} dp_status_t;

endpackage

// File: rtl/trbct_stream_if.sv
interface trbct_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/trbct_ctrl.sv
module trbct_ctrl
	import trbct_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				cmd.init_step = 1'b1;
				if (status.init_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_QUANT;
				end
			end
			ST_QUANT: begin
				cmd.quant = 1'b1;
				unique case (status.op)
					CMD_ACCUMULATE: state_d = status.pos_ok ? ST_ACC_RD : ST_DONE;
					CMD_QUANTIZE:   state_d = ST_DONE;
					CMD_READ:       state_d = (status.pos_ok && !status.n_zero) ? ST_SUM : ST_DONE;
					CMD_CLEAR:      state_d = status.pos_ok ? ST_ROW_CLR : ST_DONE;
					default:        state_d = ST_DONE;
				endcase
			end
			ST_ACC_RD: begin
				cmd.acc_rd = 1'b1;
				state_d    = ST_ACC_WR;
			end
			ST_ACC_WR: begin
				cmd.acc_wr = 1'b1;
				state_d    = ST_DONE;
			end
			ST_SUM: begin
				cmd.sum_rd = 1'b1;
				if (status.sum_last) begin
					state_d = ST_SUM_END;
				end
			end
			ST_SUM_END: begin
				state_d = ST_DONE;
			end
			ST_ROW_CLR: begin
				cmd.row_clr = 1'b1;
				if (status.row_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	// a pending result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second request taken before the first completed");

endmodule

// File: rtl/trbct_dp.sv
module trbct_dp
	import trbct_pkg::*;
#(
	parameter int MAX_POSITIONS = 4096,
	parameter int MAX_BINS      = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  in_item_t   in_data,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	output out_item_t  out_data
);

	localparam int PW    = $clog2(MAX_POSITIONS);
	localparam int BW    = $clog2(MAX_BINS);
	localparam int AW    = PW + BW;
	localparam int DEPTH = 2 ** AW;
	localparam int LW    = $clog2(MAX_BINS + 1);

	logic [7:0]         table_length_q;
	logic [AW-1:0]      init_cnt_q;
	logic [LW-1:0]      k_q;
	logic               rvalid_s1;

	logic [1:0]         cmd_q;
	logic [PW-1:0]      row_q;
	logic               pos_ok_q;
	logic signed [23:0] value_q;
	logic [7:0]         last_q;

	logic [7:0]         bin_q;
	logic               clip_q;
	logic [LW-1:0]      n_q;
	logic [15:0]        sum_q;

	logic [15:0]        mem [DEPTH];
	logic [15:0]        rdata_s1;

	logic [LW-1:0]      len;
	logic [LW-1:0]      n_d;
	logic signed [11:0] len_s;
	logic signed [29:0] fine_sum;
	logic signed [11:0] fine_raw;
	logic signed [11:0] coarse_fl;
	logic signed [11:0] coarse_half;
	logic signed [11:0] coarse_mag;
	logic signed [11:0] coarse_raw;
	logic signed [11:0] raw;
	logic               is_fine;
	logic [7:0]         bin_d;
	logic               clip_d;
	logic [BW-1:0]      acc_bin;
	logic               we;
	logic [AW-1:0]      waddr;
	logic [15:0]        wdata;
	logic               re;
	logic [AW-1:0]      raddr;
	logic [16:0]        sum_ext;
	out_item_t          out_q;

	always_comb begin
		if (table_length_q == 8'd0) begin
			len = LW'(1);
		end else if (32'(table_length_q) > MAX_BINS) begin
			len = LW'(MAX_BINS);
		end else begin
			len = LW'(table_length_q);
		end
		if (32'(last_q) > 32'(len)) begin
			n_d = len;
		end else begin
			n_d = LW'(last_q);
		end
	end

	// fine bins of 0.1 inside |v| <= 3, coarse bins of 0.5 outside
	always_comb begin
		len_s       = signed'(12'(len));
		fine_sum    = (30'(value_q) <<< 4) + (30'(value_q) <<< 2) + (30'(len) << 16);
		fine_raw    = 12'(fine_sum >>> 17);
		coarse_fl   = 12'(value_q >>> 15);
		coarse_half = (coarse_fl <<< 1) + len_s + (value_q[23] ? -12'sd48 : 12'sd48);
		coarse_mag  = coarse_half[11] ? -coarse_half : coarse_half;
		coarse_raw  = coarse_half[11] ? -(coarse_mag >>> 1) : (coarse_mag >>> 1);
		is_fine     = (value_q >= -24'sd196608) && (value_q <= 24'sd196608);
		raw         = is_fine ? fine_raw : coarse_raw;
		if (raw < 12'sd1) begin
			bin_d  = 8'd1;
			clip_d = 1'b1;
		end else if (raw > len_s) begin
			bin_d  = 8'(len);
			clip_d = 1'b1;
		end else begin
			bin_d  = 8'(raw);
			clip_d = 1'b0;
		end
	end

	assign acc_bin = BW'(bin_q - 8'd1);

	always_comb begin
		we    = cmd.init_step || cmd.acc_wr || cmd.row_clr;
		re    = cmd.acc_rd || cmd.sum_rd;
		wdata = 16'd0;
		waddr = init_cnt_q;
		raddr = {row_q, k_q[BW-1:0]};
		if (cmd.acc_wr) begin
			waddr = {row_q, acc_bin};
			wdata = (rdata_s1 == 16'hFFFF) ? rdata_s1 : rdata_s1 + 16'd1;
		end else if (cmd.row_clr) begin
			waddr = {row_q, k_q[BW-1:0]};
		end
		if (cmd.acc_rd) begin
			raddr = {row_q, acc_bin};
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q <= TABLE_LENGTH_RESET;
			init_cnt_q     <= '0;
			k_q            <= '0;
			rvalid_s1      <= 1'b0;
		end else begin
			if (cfg_we) begin
				table_length_q <= cfg_wdata;
			end
			if (cmd.init_step) begin
				init_cnt_q <= init_cnt_q + AW'(1);
			end
			if (cmd.quant) begin
				k_q <= '0;
			end else if (cmd.sum_rd || cmd.row_clr) begin
				k_q <= k_q + LW'(1);
			end
			rvalid_s1 <= cmd.sum_rd;
		end
	end

	assign sum_ext = {1'b0, sum_q} + {1'b0, rdata_s1};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q    <= in_data.command;
			row_q    <= PW'(in_data.position);
			pos_ok_q <= 32'(in_data.position) < MAX_POSITIONS;
			value_q  <= in_data.value;
			last_q   <= in_data.bin;
		end
		if (cmd.quant) begin
			bin_q  <= bin_d;
			clip_q <= clip_d;
			n_q    <= n_d;
			sum_q  <= 16'd0;
		end else if (rvalid_s1) begin
			sum_q <= sum_ext[16] ? 16'hFFFF : sum_ext[15:0];
		end
		if (cmd.out_load) begin
			unique case (command_t'(cmd_q))
				CMD_ACCUMULATE, CMD_QUANTIZE: begin
					out_q <= '{bin_index: bin_q, clamped: clip_q, cumulative_count: 16'd0};
				end
				CMD_READ: begin
					out_q <= '{bin_index: 8'd0, clamped: 1'b0, cumulative_count: sum_q};
				end
				CMD_CLEAR: begin
					out_q <= '0;
				end
				default: begin
					out_q <= '0;
				end
			endcase
		end
	end

	always_comb begin
		status.op        = command_t'(cmd_q);
		status.pos_ok    = pos_ok_q;
		status.n_zero    = (last_q == 8'd0);
		status.sum_last  = (k_q == n_q - LW'(1));
		status.row_last  = (k_q == LW'(MAX_BINS - 1));
		status.init_last = &init_cnt_q;
	end

	assign out_data = out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc_wr |-> $past(cmd.acc_rd))
		else $error("count write without its read");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.row_clr || cmd.sum_rd || cmd.acc_rd) |-> pos_ok_q)
		else $error("row access with position out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sum_rd |-> (32'(k_q) < 32'(n_q)))
		else $error("cumulative read beyond bin limit");

endmodule

// File: rtl/two_resolution_binned_count_table.sv
// Each accepted request passes ST_QUANT; accumulate then reads and increments its count,
// read walks min(bin, length) bins (none when that is zero), clear walks all MAX_BINS bins.
// One request at a time: the next can be taken in the cycle after the result is loaded;
// a waiting result holds the next back, and the per-bin walk of reads and clears sets the rest.
// Reset: table_length returns to 60, then a clearing pass writes zero to all
// 2**(clog2(MAX_POSITIONS) + clog2(MAX_BINS)) words, one a cycle, before the first request.
module two_resolution_binned_count_table
	import trbct_pkg::*;
#(
	parameter int MAX_POSITIONS = 4096,
	parameter int MAX_BINS      = 128
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [7:0]     cfg_wdata,
	trbct_stream_if.sink   items,
	trbct_stream_if.source results
);

	dp_cmd_t    cmd;
	dp_status_t status;
	out_item_t  out_data;

	trbct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_ready  (items.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.status    (status),
		.cmd       (cmd)
	);

	trbct_dp #(
		.MAX_POSITIONS (MAX_POSITIONS),
		.MAX_BINS      (MAX_BINS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (items.data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

	assign results.data = out_data;

endmodule
